FILE: design/bcsm_pkg.sv
// ----------------------------------------------------------------------------
// bcsm_pkg: shared types of the block cache clock sweep manager
// request and result codes, per-slot cell command and status
// ----------------------------------------------------------------------------
package bcsm_pkg;

  localparam int SLOT_W = 5;
  localparam logic [5:0] FREE_NONE = 6'd63;

  typedef enum logic [2:0] {
    REQ_LOOKUP = 3'd0,
    REQ_MARK   = 3'd1,
    REQ_INVAL  = 3'd2,
    REQ_FLUSH  = 3'd3,
    REQ_STATS  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    KIND_HIT   = 3'd0,
    KIND_FILL  = 3'd1,
    KIND_WB    = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_STATS = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_SWEEP,
    S_SWEEP_WB,
    S_FILL,
    S_SCAN,
    S_DONE,
    S_STATS
  } state_t;

  typedef enum logic [2:0] {
    CO_NONE,
    CO_FILL,
    CO_HIT,
    CO_DEC,
    CO_SET_DIRTY,
    CO_CLR_DIRTY,
    CO_INVAL
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [SLOT_W-1:0] sel;
    logic [31:0]       lg;
    logic [31:0]       blk;
    logic [2:0]        cap;
    logic [5:0]        next;
  } cell_cmd_t;

  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [2:0]  usage;
    logic [5:0]  free_next;
    logic [31:0] tag_log;
    logic [31:0] tag_block;
  } cell_stat_t;

endpackage

FILE: design/bcsm_ifs.sv
// ----------------------------------------------------------------------------
// bcsm_ifs: request and result channels
// valid/ready handshake with payload
// ----------------------------------------------------------------------------
interface bcsm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] log_id;
  logic [31:0] block_id;
  logic [4:0]  slot_index;
  modport source (output valid, req_type, log_id, block_id, slot_index, input ready);
  modport sink   (input valid, req_type, log_id, block_id, slot_index, output ready);
endinterface

interface bcsm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [4:0]  slot;
  logic [31:0] out_log;
  logic [31:0] out_block;
  logic        last;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] evict_total;
  logic [31:0] write_total;
  modport source (output valid, kind, slot, out_log, out_block, last, hit_total,
                  miss_total, evict_total, write_total, input ready);
  modport sink   (input valid, kind, slot, out_log, out_block, last, hit_total,
                  miss_total, evict_total, write_total, output ready);
endinterface

FILE: design/block_cache_clock_sweep_manager_top.sv
// ----------------------------------------------------------------------------
// block_cache_clock_sweep_manager_top: tag manager with clock-sweep replacement
// row of slot cells plus a sequencer for lookup, sweep and scans
// ----------------------------------------------------------------------------
// throughput: one transaction at a time, a new one accepted once the last
// result is loaded; the sweep visits one slot per cycle
// reset: synchronous active-low; slots invalid, free list 0..NUM_SLOTS-1,
// counters zero, usage cap 5
module block_cache_clock_sweep_manager_top import bcsm_pkg::*; #(
  parameter int NUM_SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  bcsm_in_if.sink    in_chan,
  bcsm_out_if.source out_chan
);

  localparam int IW = $clog2(NUM_SLOTS);

  state_t      state_r, state_nxt;
  logic [2:0]  cap_r;
  logic [2:0]  req_r, req_nxt;
  logic [31:0] log_r, log_nxt, blk_r, blk_nxt;
  logic [IW-1:0] slot_r, slot_nxt, scan_r, scan_nxt, hand_r, hand_nxt;
  logic [5:0]  head_r, head_nxt;
  logic [31:0] cnt_r [4];
  logic [3:0]  bump;

  // output register
  logic        ov_r;
  logic [2:0]  okind_r;
  logic [4:0]  oslot_r;
  logic [31:0] olog_r, oblk_r;
  logic        olast_r;
  logic [31:0] ostat_r [4];

  // emit request from the sequencer
  logic        emit, e_last, e_stats;
  kind_t       e_kind;
  logic [IW-1:0] e_slot;
  logic [31:0] e_log, e_blk;

  // cell row
  cell_cmd_t   cmd;
  cell_op_t    c_op;
  logic [IW-1:0] c_sel;
  cell_stat_t  stat [NUM_SLOTS];
  logic [NUM_SLOTS:0] chain;
  logic [NUM_SLOTS-1:0] hit_vec;
  logic [IW-1:0] hit_idx, probe;
  cell_stat_t  ps;

  logic accept, out_free, any_hit, free_ok, scan_match, scan_wb, scan_stall, scan_last;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !ov_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  // lookups and scans compare against the held request
  assign cmd = '{op: c_op, sel: SLOT_W'(c_sel), lg: log_r, blk: blk_r, cap: cap_r,
                 next: head_r};
  assign chain[0] = 1'b0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    bcsm_cell #(.NUM_SLOTS(NUM_SLOTS), .CELL_IDX(g)) u_cell (
      .clk, .rst_n, .cmd,
      .found_in (chain[g]),
      .found_out(chain[g+1]),
      .hit      (hit_vec[g]),
      .stat     (stat[g])
    );
  end

  assign any_hit = chain[NUM_SLOTS];

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hit_vec[i]) hit_idx = hit_idx | IW'(i);
    end
  end

  // one slot is looked at per cycle
  always_comb begin
    unique case (state_r)
      S_SWEEP:  probe = hand_r;
      S_SCAN:   probe = scan_r;
      S_LOOKUP: probe = head_r[IW-1:0];
      default:  probe = slot_r;
    endcase
  end
  assign ps = stat[probe];

  assign free_ok    = head_r < 6'(NUM_SLOTS);
  assign scan_match = (req_r == REQ_INVAL) ? (ps.valid && ps.tag_log == log_r)
                                           : (ps.valid && ps.dirty);
  assign scan_wb    = scan_match && ps.dirty;
  assign scan_stall = scan_wb && !out_free;
  assign scan_last  = (scan_r == IW'(NUM_SLOTS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_chan.req_type)
            REQ_LOOKUP:           state_nxt = S_LOOKUP;
            REQ_INVAL, REQ_FLUSH: state_nxt = S_SCAN;
            REQ_STATS:            state_nxt = S_STATS;
            default:              state_nxt = S_DONE;
          endcase
        end
      end
      S_LOOKUP: begin
        if (any_hit) begin
          if (out_free) state_nxt = S_IDLE;
        end else begin
          state_nxt = free_ok ? S_FILL : S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (!ps.valid)            state_nxt = S_FILL;
        else if (ps.usage != '0)  state_nxt = S_SWEEP;
        else if (ps.dirty)        state_nxt = S_SWEEP_WB;
        else                      state_nxt = S_FILL;
      end
      S_SWEEP_WB: if (out_free) state_nxt = S_FILL;
      S_FILL:     if (out_free) state_nxt = S_IDLE;
      S_SCAN:     if (!scan_stall && scan_last) state_nxt = S_DONE;
      S_DONE, S_STATS: if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    req_nxt  = req_r;
    log_nxt  = log_r;
    blk_nxt  = blk_r;
    slot_nxt = slot_r;
    scan_nxt = scan_r;
    hand_nxt = hand_r;
    head_nxt = head_r;
    bump     = '0;
    c_op     = CO_NONE;
    c_sel    = probe;
    emit     = 1'b0;
    e_kind   = KIND_DONE;
    e_slot   = '0;
    e_log    = '0;
    e_blk    = '0;
    e_last   = 1'b1;
    e_stats  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt  = in_chan.req_type;
          log_nxt  = in_chan.log_id;
          blk_nxt  = in_chan.block_id;
          scan_nxt = '0;
          if (in_chan.req_type == REQ_MARK &&
              {1'b0, in_chan.slot_index} < 6'(NUM_SLOTS)) begin
            c_op  = CO_SET_DIRTY;
            c_sel = in_chan.slot_index[IW-1:0];
          end
        end
      end
      S_LOOKUP: begin
        if (any_hit) begin
          if (out_free) begin
            c_op   = CO_HIT;
            c_sel  = hit_idx;
            bump   = 4'b0001;
            emit   = 1'b1;
            e_kind = KIND_HIT;
            e_slot = hit_idx;
            e_log  = log_r;
            e_blk  = blk_r;
          end
        end else begin
          bump = 4'b0010;
          if (free_ok) begin
            slot_nxt = head_r[IW-1:0];
            head_nxt = ps.free_next;
          end
        end
      end
      S_SWEEP: begin
        hand_nxt = (hand_r == IW'(NUM_SLOTS - 1)) ? '0 : hand_r + IW'(1);
        slot_nxt = hand_r;
        if (ps.valid && ps.usage != '0) c_op = CO_DEC;
        else if (ps.valid && !ps.dirty) bump = 4'b0100;
      end
      S_SWEEP_WB: begin
        if (out_free) begin
          c_op   = CO_CLR_DIRTY;
          bump   = 4'b1100;
          emit   = 1'b1;
          e_kind = KIND_WB;
          e_slot = slot_r;
          e_log  = ps.tag_log;
          e_blk  = ps.tag_block;
          e_last = 1'b0;
        end
      end
      S_FILL: begin
        if (out_free) begin
          c_op   = CO_FILL;
          emit   = 1'b1;
          e_kind = KIND_FILL;
          e_slot = slot_r;
          e_log  = log_r;
          e_blk  = blk_r;
        end
      end
      S_SCAN: begin
        if (!scan_stall) begin
          scan_nxt = scan_r + IW'(1);
          if (scan_match) begin
            if (req_r == REQ_INVAL) begin
              c_op     = CO_INVAL;
              head_nxt = {{(6-IW){1'b0}}, scan_r};
            end else begin
              c_op = CO_CLR_DIRTY;
            end
          end
          if (scan_wb) begin
            bump   = 4'b1000;
            emit   = 1'b1;
            e_kind = KIND_WB;
            e_slot = scan_r;
            e_log  = ps.tag_log;
            e_blk  = ps.tag_block;
            e_last = 1'b0;
          end
        end
      end
      S_DONE: emit = out_free;
      S_STATS: begin
        emit    = out_free;
        e_kind  = KIND_STATS;
        e_stats = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= 3'd5;
      hand_r  <= '0;
      head_r  <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < 4; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      hand_r  <= hand_nxt;
      head_r  <= head_nxt;
      if (cfg_we) cap_r <= cfg_data;
      for (int i = 0; i < 4; i++) begin
        if (bump[i] && cnt_r[i] != '1) cnt_r[i] <= cnt_r[i] + 32'd1;
      end
      if (emit)                ov_r <= 1'b1;
      else if (out_chan.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    log_r  <= log_nxt;
    blk_r  <= blk_nxt;
    slot_r <= slot_nxt;
    scan_r <= scan_nxt;
    if (emit) begin
      okind_r <= e_kind;
      oslot_r <= 5'(e_slot);
      olog_r  <= e_log;
      oblk_r  <= e_blk;
      olast_r <= e_last;
      for (int i = 0; i < 4; i++) ostat_r[i] <= e_stats ? cnt_r[i] : 32'd0;
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.kind        = okind_r;
  assign out_chan.slot        = oslot_r;
  assign out_chan.out_log     = olog_r;
  assign out_chan.out_block   = oblk_r;
  assign out_chan.last        = olast_r;
  assign out_chan.hit_total   = ostat_r[0];
  assign out_chan.miss_total  = ostat_r[1];
  assign out_chan.evict_total = ostat_r[2];
  assign out_chan.write_total = ostat_r[3];

  // every accepted transaction leaves idle to produce a result
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE) else $error("request dropped");

  // at most one cell claims a hit
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec)) else $error("multiple hits");

  // sweep writeback only for a valid dirty victim
  a_sweep_wb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP_WB |-> ps.valid && ps.dirty) else $error("bad victim");

  // a slot at the free list head is never valid
  a_free_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP && free_ok) |-> !ps.valid) else $error("free slot valid");

endmodule

FILE: design/bcsm_cell.sv
// ----------------------------------------------------------------------------
// bcsm_cell: one cache slot
// holds tag, flags, usage count and free link; passes the hit chain on
// ----------------------------------------------------------------------------
module bcsm_cell import bcsm_pkg::*; #(
  parameter int NUM_SLOTS = 32,
  parameter int CELL_IDX  = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  logic       found_in,
  output logic       found_out,
  output logic       hit,
  output cell_stat_t stat
);

  logic        valid_r, dirty_r;
  logic [2:0]  usage_r;
  logic [5:0]  next_r;
  logic [31:0] log_r, blk_r;
  logic        me, match;

  assign me        = (cmd.sel == SLOT_W'(CELL_IDX));
  assign match     = valid_r && (log_r == cmd.lg) && (blk_r == cmd.blk);
  assign hit       = match && !found_in;
  assign found_out = found_in || match;
  assign stat      = '{valid: valid_r, dirty: dirty_r, usage: usage_r,
                       free_next: next_r, tag_log: log_r, tag_block: blk_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      usage_r <= '0;
      next_r  <= (CELL_IDX + 1 < NUM_SLOTS) ? 6'(CELL_IDX + 1) : FREE_NONE;
    end else if (me) begin
      unique case (cmd.op)
        CO_FILL: begin
          valid_r <= 1'b1;
          dirty_r <= 1'b0;
          usage_r <= 3'd1;
          next_r  <= FREE_NONE;
        end
        CO_HIT:       if (usage_r < cmd.cap) usage_r <= usage_r + 3'd1;
        CO_DEC:       usage_r <= usage_r - 3'd1;
        CO_SET_DIRTY: dirty_r <= 1'b1;
        CO_CLR_DIRTY: dirty_r <= 1'b0;
        CO_INVAL: begin
          valid_r <= 1'b0;
          dirty_r <= 1'b0;
          next_r  <= cmd.next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (me && cmd.op == CO_FILL) begin
      log_r <= cmd.lg;
      blk_r <= cmd.blk;
    end
  end

endmodule
